// File: sv/htti_pkg.sv
// Shared constants, types and the compensation table for the humidity and
// temperature table interpolator. No dependencies.
package htti_pkg;

  // Field widths of the stream words.
  localparam int HUM_W = 10;
  localparam int TMP_W = 10;
  localparam int FAC_W = 8;

  // Internal widths.
  localparam int ROW_W   = 3;   // table row index, five rows
  localparam int COL_W   = 2;   // table column index, three columns
  localparam int DIFF_W  = 5;   // neighbor column difference, at most 30
  localparam int HMAG_W  = 15;  // |humidity offset| times column difference
  localparam int Y_W     = 10;  // signed row value after humidity step
  localparam int DT_W    = 8;   // signed temperature offset in its segment
  localparam int TMAG_W  = 17;  // |temperature offset| times |row difference|
  localparam int HQ_W    = 8;   // quotient of the humidity step
  localparam int TQ_W    = 11;  // quotient of the temperature step

  // Division by a constant span is a multiply by a rounded-up reciprocal.
  // With this shift the quotient is exact for every dividend below 2**16.
  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = 18;

  localparam int HUM_SPAN_LO = 250;
  localparam int HUM_SPAN_HI = 200;
  localparam int TMP_SPAN    = 100;

  localparam logic [RECIP_W-1:0] RECIP_HLO =
    RECIP_W'(((1 << DIV_SHIFT) + HUM_SPAN_LO - 1) / HUM_SPAN_LO);
  localparam logic [RECIP_W-1:0] RECIP_HHI =
    RECIP_W'(((1 << DIV_SHIFT) + HUM_SPAN_HI - 1) / HUM_SPAN_HI);
  localparam logic [RECIP_W-1:0] RECIP_T =
    RECIP_W'(((1 << DIV_SHIFT) + TMP_SPAN - 1) / TMP_SPAN);

  // Humidity columns and temperature rows of the table.
  localparam logic [HUM_W-1:0] HUM_PTS [3] = '{10'd400, 10'd650, 10'd850};
  localparam logic [TMP_W-1:0] TMP_PTS [5] =
    '{10'd100, 10'd200, 10'd300, 10'd400, 10'd500};

  // Result when the temperature lies above the last row.
  localparam logic [FAC_W-1:0] FAC_HOT = 8'd1;

  // Resistance factor table, rows by temperature, columns by humidity.
  localparam logic [FAC_W-1:0] FAC_TAB [5][3] = '{
    '{8'd161, 8'd142, 8'd125},
    '{8'd130, 8'd100, 8'd93},
    '{8'd99,  8'd80,  8'd70},
    '{8'd78,  8'd61,  8'd54},
    '{8'd63,  8'd48,  8'd43}
  };

  // Word handed from the humidity stages to the temperature stages.
  typedef struct packed {
    logic                   hot;
    logic signed [Y_W-1:0]  y_lo;
    logic signed [Y_W-1:0]  y_hi;
    logic signed [DT_W-1:0] dt;
  } hrow_t;

endpackage

// File: sv/humidity_temperature_table_interp_top.sv
// Humidity and temperature compensation factor by bilinear table lookup.
// Depends on htti_pkg, htti_hstage and htti_tstage.
//
// Usage: present a word of humidity (tenths of a percent) and temperature
// (tenths of a degree) on the in_ channel; each word gives exactly one
// resistance factor word on the out_ channel, in order. Both channels use
// valid and ready. There are no configuration registers.
// Pipeline: four register stages: table selection, humidity divide,
// temperature product, and temperature divide with the output register.
// Throughput: one word per cycle while out_ready is high; every stage
// register holds one word.
// Stall: when a result waits with out_ready low, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated. in_ready is high
// whenever the output register is empty or being taken.
// Reset: synchronous, active low; all valid bits clear, so the block
// comes up empty and ready.
module humidity_temperature_table_interp_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [htti_pkg::HUM_W-1:0]  in_humidity,
  input  logic [htti_pkg::TMP_W-1:0]  in_temperature,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [htti_pkg::FAC_W-1:0]  out_resistance_factor
);

  logic            en;
  logic            row_valid;
  htti_pkg::hrow_t row_word;

  // The pipeline advances whenever the output register is free.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  htti_hstage u_hstage (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .humidity    (in_humidity),
    .temperature (in_temperature),
    .row_valid   (row_valid),
    .row_word    (row_word)
  );

  htti_tstage u_tstage (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .row_valid  (row_valid),
    .row_word   (row_word),
    .res_valid  (out_valid),
    .res_factor (out_resistance_factor)
  );

endmodule

// File: sv/htti_hstage.sv
// Humidity stages: table selection with the offset products, then the
// reciprocal divide that yields both row values. Depends on htti_pkg.
module htti_hstage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [htti_pkg::HUM_W-1:0]  humidity,
  input  logic [htti_pkg::TMP_W-1:0]  temperature,
  output logic                        row_valid,
  output htti_pkg::hrow_t             row_word
);

  // Stage A combinational signals.
  logic                               col_hi;
  logic                               hot;
  logic [htti_pkg::ROW_W-1:0]         r_lo;
  logic [htti_pkg::ROW_W-1:0]         r_hi;
  logic [htti_pkg::COL_W-1:0]         c_lo;
  logic [htti_pkg::COL_W-1:0]         c_hi;
  logic [htti_pkg::FAC_W-1:0]         b_lo;
  logic [htti_pkg::FAC_W-1:0]         b_hi;
  logic [htti_pkg::FAC_W-1:0]         a_lo;
  logic [htti_pkg::FAC_W-1:0]         a_hi;
  logic [htti_pkg::DIFF_W-1:0]        d_lo;
  logic [htti_pkg::DIFF_W-1:0]        d_hi;
  logic [htti_pkg::HUM_W-1:0]         h0;
  logic [htti_pkg::TMP_W-1:0]         t0;
  logic signed [htti_pkg::HUM_W:0]    dh;
  logic [htti_pkg::HUM_W-1:0]         dh_mag;
  logic signed [htti_pkg::TMP_W:0]    dt_full;

  // Stage A registers.
  logic                               a_v_r;
  logic                               a_hot_r;
  logic                               a_col_hi_r;
  logic                               a_neg_r;
  logic [htti_pkg::FAC_W-1:0]         a_lo_r;
  logic [htti_pkg::FAC_W-1:0]         a_hi_r;
  logic [htti_pkg::HMAG_W-1:0]        a_pm_lo_r;
  logic [htti_pkg::HMAG_W-1:0]        a_pm_hi_r;
  logic signed [htti_pkg::DT_W-1:0]   a_dt_r;

  // Stage B combinational signals.
  logic [htti_pkg::RECIP_W-1:0]       recip;
  logic [htti_pkg::HMAG_W+htti_pkg::RECIP_W-1:0] prod_lo;
  logic [htti_pkg::HMAG_W+htti_pkg::RECIP_W-1:0] prod_hi;
  logic [htti_pkg::HQ_W-1:0]          q_lo;
  logic [htti_pkg::HQ_W-1:0]          q_hi;
  htti_pkg::hrow_t                    b_nxt;

  // Stage B registers.
  logic                               b_v_r;
  htti_pkg::hrow_t                    b_word_r;

  // Pick the column pair and the temperature segment, then form the
  // magnitude of the humidity offset times each row's column difference.
  always_comb begin
    col_hi = (humidity > htti_pkg::HUM_PTS[1]);
    hot    = 1'b0;
    if (temperature <= htti_pkg::TMP_PTS[1]) begin
      r_lo = 3'd0;
    end else if (temperature <= htti_pkg::TMP_PTS[2]) begin
      r_lo = 3'd1;
    end else if (temperature <= htti_pkg::TMP_PTS[3]) begin
      r_lo = 3'd2;
    end else if (temperature <= htti_pkg::TMP_PTS[4]) begin
      r_lo = 3'd3;
    end else begin
      r_lo = 3'd0;
      hot  = 1'b1;
    end
    r_hi = r_lo + 3'd1;
    c_lo = col_hi ? 2'd1 : 2'd0;
    c_hi = col_hi ? 2'd2 : 2'd1;

    a_lo = htti_pkg::FAC_TAB[r_lo][c_lo];
    b_lo = htti_pkg::FAC_TAB[r_lo][c_hi];
    a_hi = htti_pkg::FAC_TAB[r_hi][c_lo];
    b_hi = htti_pkg::FAC_TAB[r_hi][c_hi];
    d_lo = htti_pkg::DIFF_W'(a_lo - b_lo);
    d_hi = htti_pkg::DIFF_W'(a_hi - b_hi);

    h0     = col_hi ? htti_pkg::HUM_PTS[1] : htti_pkg::HUM_PTS[0];
    dh     = $signed({1'b0, humidity}) - $signed({1'b0, h0});
    dh_mag = dh[htti_pkg::HUM_W] ? htti_pkg::HUM_W'(-dh) : htti_pkg::HUM_W'(dh);

    t0      = htti_pkg::TMP_PTS[r_lo];
    dt_full = $signed({1'b0, temperature}) - $signed({1'b0, t0});
  end

  // Stage A register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
    if (en) begin
      a_hot_r    <= hot;
      a_col_hi_r <= col_hi;
      a_neg_r    <= dh[htti_pkg::HUM_W];
      a_lo_r     <= a_lo;
      a_hi_r     <= a_hi;
      a_pm_lo_r  <= htti_pkg::HMAG_W'(dh_mag) * htti_pkg::HMAG_W'(d_lo);
      a_pm_hi_r  <= htti_pkg::HMAG_W'(dh_mag) * htti_pkg::HMAG_W'(d_hi);
      a_dt_r     <= htti_pkg::DT_W'(dt_full);
    end
  end

  // Divide by the column span through the exact reciprocal, then apply the
  // offset's sign: the quotient truncates toward zero.
  always_comb begin
    recip   = a_col_hi_r ? htti_pkg::RECIP_HHI : htti_pkg::RECIP_HLO;
    prod_lo = (htti_pkg::HMAG_W + htti_pkg::RECIP_W)'(a_pm_lo_r) *
              (htti_pkg::HMAG_W + htti_pkg::RECIP_W)'(recip);
    prod_hi = (htti_pkg::HMAG_W + htti_pkg::RECIP_W)'(a_pm_hi_r) *
              (htti_pkg::HMAG_W + htti_pkg::RECIP_W)'(recip);
    q_lo    = prod_lo[htti_pkg::DIV_SHIFT +: htti_pkg::HQ_W];
    q_hi    = prod_hi[htti_pkg::DIV_SHIFT +: htti_pkg::HQ_W];

    b_nxt.hot = a_hot_r;
    b_nxt.dt  = a_dt_r;
    if (a_neg_r) begin
      b_nxt.y_lo = $signed({2'b00, a_lo_r}) + $signed({2'b00, q_lo});
      b_nxt.y_hi = $signed({2'b00, a_hi_r}) + $signed({2'b00, q_hi});
    end else begin
      b_nxt.y_lo = $signed({2'b00, a_lo_r}) - $signed({2'b00, q_lo});
      b_nxt.y_hi = $signed({2'b00, a_hi_r}) - $signed({2'b00, q_hi});
    end
  end

  // Stage B register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_word_r <= b_nxt;
    end
  end

  assign row_valid = b_v_r;
  assign row_word  = b_word_r;

endmodule

// File: sv/htti_tstage.sv
// Temperature stages: offset product between the two row values, then the
// reciprocal divide and the output register. Depends on htti_pkg.
module htti_tstage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        row_valid,
  input  htti_pkg::hrow_t             row_word,
  output logic                        res_valid,
  output logic [htti_pkg::FAC_W-1:0]  res_factor
);

  // Stage C combinational signals.
  logic signed [htti_pkg::Y_W:0]      dy;
  logic [htti_pkg::Y_W-1:0]           dy_mag;
  logic [htti_pkg::DT_W-2:0]          dt_mag;

  // Stage C registers.
  logic                               c_v_r;
  logic                               c_hot_r;
  logic                               c_neg_r;
  logic signed [htti_pkg::Y_W-1:0]    c_y_r;
  logic [htti_pkg::TMAG_W-1:0]        c_pm_r;

  // Stage D combinational signals.
  logic [htti_pkg::TMAG_W+htti_pkg::RECIP_W-1:0] prod;
  logic [htti_pkg::TQ_W-1:0]          q;
  logic [htti_pkg::TQ_W:0]            res;
  logic [htti_pkg::FAC_W-1:0]         fac_nxt;

  // Output registers.
  logic                               out_v_r;
  logic [htti_pkg::FAC_W-1:0]         out_fac_r;

  // Magnitudes of the temperature offset and of the row difference.
  always_comb begin
    dy     = $signed({row_word.y_lo[htti_pkg::Y_W-1], row_word.y_lo}) -
             $signed({row_word.y_hi[htti_pkg::Y_W-1], row_word.y_hi});
    dy_mag = dy[htti_pkg::Y_W] ? htti_pkg::Y_W'(-dy) : htti_pkg::Y_W'(dy);
    dt_mag = row_word.dt[htti_pkg::DT_W-1] ? (htti_pkg::DT_W-1)'(-row_word.dt)
                                           : (htti_pkg::DT_W-1)'(row_word.dt);
  end

  // Stage C register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= row_valid;
    end
    if (en) begin
      c_hot_r <= row_word.hot;
      c_neg_r <= row_word.dt[htti_pkg::DT_W-1] ^ dy[htti_pkg::Y_W];
      c_y_r   <= row_word.y_lo;
      c_pm_r  <= htti_pkg::TMAG_W'(dt_mag) * htti_pkg::TMAG_W'(dy_mag);
    end
  end

  // Divide by the segment span and step from the lower row value; only the
  // low byte of the result is kept.
  always_comb begin
    prod = (htti_pkg::TMAG_W + htti_pkg::RECIP_W)'(c_pm_r) *
           (htti_pkg::TMAG_W + htti_pkg::RECIP_W)'(htti_pkg::RECIP_T);
    q    = prod[htti_pkg::DIV_SHIFT +: htti_pkg::TQ_W];
    if (c_neg_r) begin
      res = (htti_pkg::TQ_W + 1)'(c_y_r) + {1'b0, q};
    end else begin
      res = (htti_pkg::TQ_W + 1)'(c_y_r) - {1'b0, q};
    end
    fac_nxt = c_hot_r ? htti_pkg::FAC_HOT : res[htti_pkg::FAC_W-1:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= c_v_r;
    end
    if (en) begin
      out_fac_r <= fac_nxt;
    end
  end

  assign res_valid  = out_v_r;
  assign res_factor = out_fac_r;

endmodule
